[hw/rtl/ctt_pkg.sv]
// Package for the connection timer table: request codes, field widths
// and default sizes. No dependencies.
`timescale 1ns / 1ps

package ctt_pkg;

  // Default sizes of the table
  localparam int DEF_NUM_CONNS  = 64;
  localparam int DEF_NUM_TIMERS = 6;
  localparam int DEF_COUNT_BITS = 16;

  // Fixed field widths of the stream payloads
  localparam int REQ_BITS      = 3;
  localparam int SLOT_BITS     = 6;
  localparam int TIDX_BITS     = 3;
  localparam int TICK_BITS     = 16;
  localparam int MASK_BITS     = 6;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 16;

  // max_open after reset
  localparam logic [SLOT_BITS-1:0] MAX_OPEN_RESET = 6'd63;

  // Request codes; the eighth code is unused and ignored
  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK      = 3'd0,
    REQ_SET       = 3'd1,
    REQ_SET_MIN   = 3'd2,
    REQ_SET_EARLY = 3'd3,
    REQ_CANCEL    = 3'd4,
    REQ_OPEN      = 3'd5,
    REQ_CLOSE     = 3'd6
  } req_t;

endpackage

[hw/rtl/ctt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone, no package dependency.
`timescale 1ns / 1ps

module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/connection_timer_table.sv]
// Connection timer table top level: request decode, sweep sequencer and
// result register around one row-per-connection RAM. Uses ctt_pkg, ctt_ram.
`timescale 1ns / 1ps
//
//  channel   dir  tdata fields (low bit up)                   tuser     tlast
//  s_axis    in   conn_slot, timer_index, tick_count, pad     req_type  -
//  m_axis    out  expired_conn, expired_mask, pad             -         last_expiry
//  cfg       in   cfg_wr_data = max_open, written on cfg_wr_en
//
//  A set, cancel, open or close request is a RAM read, then a modify and
//  write back of the connection's row. A tick walks the slots from
//  max_open down to 1 (read, update, emit per slot), then does the stop
//  check and the flush, plus any time the result register waits on
//  m_axis_tready.
//  After reset a clearing pass zeroes every RAM row; no transaction is
//  accepted until it ends.

module connection_timer_table
  import ctt_pkg::*;
#(
  parameter int NUM_CONNS  = DEF_NUM_CONNS,
  parameter int NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // request stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [5:0] conn_slot, [8:6] timer_index, [24:9] tick_count, [31:25] zero
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [REQ_BITS-1:0]      s_axis_tuser,
  // expiry stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [5:0] expired_conn, [11:6] expired_mask, [15:12] zero
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [SLOT_BITS-1:0]     cfg_wr_data
);

  localparam int AW    = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
  localparam int ROW_W = NUM_TIMERS * COUNT_BITS + 1;  // open flag on top

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RQ_DATA,
    ST_SW_ADDR,
    ST_SW_DATA,
    ST_SW_EMIT,
    ST_FLUSH
  } state_t;

  state_t                  state;
  logic [AW-1:0]           clr_addr;
  logic [SLOT_BITS-1:0]    max_open;

  // latched request
  req_t                    req_r;
  logic [AW-1:0]           slot_r;
  logic [TIDX_BITS-1:0]    tidx_r;
  logic [COUNT_BITS-1:0]   ticks_r;

  // sweep state
  logic [SLOT_BITS-1:0]    sweep_slot;
  logic [MASK_BITS-1:0]    new_mask;
  logic                    pend_valid;
  logic [SLOT_BITS-1:0]    pend_conn;
  logic [MASK_BITS-1:0]    pend_mask;

  // result register
  logic                    out_valid;
  logic [SLOT_BITS-1:0]    out_conn;
  logic [MASK_BITS-1:0]    out_mask;
  logic                    out_last;

  // RAM ports
  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  logic [ROW_W-1:0]        ram_wr_data;
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [ROW_W-1:0]        ram_rd_data;

  // input field split
  logic [SLOT_BITS-1:0]    in_slot;
  logic [TIDX_BITS-1:0]    in_tidx;
  logic [TICK_BITS-1:0]    in_ticks;
  req_t                    in_req;
  logic                    in_accept;
  logic                    slot_ok;
  logic                    tidx_ok;
  logic                    in_rmw;

  // modified rows
  logic [ROW_W-1:0]        rq_row;
  logic [ROW_W-1:0]        sw_row;
  logic [MASK_BITS-1:0]    sw_mask;
  logic                    out_free;

  assign in_slot   = s_axis_tdata[SLOT_BITS-1:0];
  assign in_tidx   = s_axis_tdata[SLOT_BITS +: TIDX_BITS];
  assign in_ticks  = s_axis_tdata[SLOT_BITS+TIDX_BITS +: TICK_BITS];
  assign in_req    = req_t'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign slot_ok   = int'(in_slot) < NUM_CONNS;
  assign tidx_ok   = int'(in_tidx) < NUM_TIMERS;
  assign out_free  = !out_valid || m_axis_tready;

  // Which accepted requests need a read-modify-write of their row
  always_comb begin
    unique case (in_req)
      REQ_OPEN, REQ_CLOSE: in_rmw = slot_ok;
      REQ_SET, REQ_SET_MIN, REQ_SET_EARLY, REQ_CANCEL:
        in_rmw = slot_ok && tidx_ok;
      default: in_rmw = 1'b0;
    endcase
  end

  // Request update of one timer or the open flag
  always_comb begin
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] ticks_nz;
    rq_row   = ram_rd_data;
    ticks_nz = (ticks_r == '0) ? COUNT_BITS'(1) : ticks_r;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      cur = ram_rd_data[t*COUNT_BITS +: COUNT_BITS];
      if (int'(tidx_r) == t) begin
        unique case (req_r)
          REQ_SET:     rq_row[t*COUNT_BITS +: COUNT_BITS] = ticks_nz;
          REQ_SET_MIN: begin
            if (cur == '0 || ticks_r < cur) begin
              rq_row[t*COUNT_BITS +: COUNT_BITS] = ticks_r;
            end
          end
          REQ_SET_EARLY: begin
            if (cur == '0 || cur > ticks_nz) begin
              rq_row[t*COUNT_BITS +: COUNT_BITS] = ticks_nz;
            end
          end
          REQ_CANCEL:  rq_row[t*COUNT_BITS +: COUNT_BITS] = '0;
          default:     ;
        endcase
      end
    end
    if (req_r == REQ_OPEN) begin
      rq_row[ROW_W-1] = 1'b1;
    end else if (req_r == REQ_CLOSE) begin
      rq_row[ROW_W-1] = 1'b0;
    end
  end

  // Tick update of one row: decrement active timers of an open slot
  always_comb begin
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] dec;
    sw_row  = ram_rd_data;
    sw_mask = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      cur = ram_rd_data[t*COUNT_BITS +: COUNT_BITS];
      dec = cur - COUNT_BITS'(1);
      if (ram_rd_data[ROW_W-1] && cur != '0) begin
        sw_row[t*COUNT_BITS +: COUNT_BITS] = dec;
        if (dec == '0 && t < MASK_BITS) begin
          sw_mask[t] = 1'b1;
        end
      end
    end
  end

  // RAM port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot_r;
    ram_wr_data = rq_row;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(in_slot);
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_IDLE:    ram_rd_en = in_accept && in_rmw;
      ST_RQ_DATA: ram_wr_en = 1'b1;
      ST_SW_ADDR: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(sweep_slot);
      end
      ST_SW_DATA: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = AW'(sweep_slot);
        ram_wr_data = sw_row;
      end
      default: ;
    endcase
  end

  ctt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_CONNS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_open <= MAX_OPEN_RESET;
    end else if (cfg_wr_en) begin
      max_open <= cfg_wr_data;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_CONNS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            req_r   <= in_req;
            slot_r  <= AW'(in_slot);
            tidx_r  <= in_tidx;
            ticks_r <= COUNT_BITS'(in_ticks);
            if (in_req == REQ_TICK) begin
              sweep_slot <= max_open;
              state      <= ST_SW_ADDR;
            end else if (in_rmw) begin
              state <= ST_RQ_DATA;
            end
          end
        end
        ST_RQ_DATA: state <= ST_IDLE;
        // Walk slots downward, skipping those beyond the table
        ST_SW_ADDR: begin
          if (sweep_slot == '0) begin
            state <= ST_FLUSH;
          end else if (int'(sweep_slot) >= NUM_CONNS) begin
            sweep_slot <= sweep_slot - SLOT_BITS'(1);
          end else begin
            state <= ST_SW_DATA;
          end
        end
        ST_SW_DATA: begin
          new_mask <= sw_mask;
          state    <= ST_SW_EMIT;
        end
        // Hold one result back so the final one can carry tlast
        ST_SW_EMIT: begin
          if (new_mask == '0) begin
            sweep_slot <= sweep_slot - SLOT_BITS'(1);
            state      <= ST_SW_ADDR;
          end else if (!pend_valid) begin
            pend_valid <= 1'b1;
            pend_conn  <= sweep_slot;
            pend_mask  <= new_mask;
            sweep_slot <= sweep_slot - SLOT_BITS'(1);
            state      <= ST_SW_ADDR;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_conn   <= pend_conn;
            out_mask   <= pend_mask;
            out_last   <= 1'b0;
            pend_conn  <= sweep_slot;
            pend_mask  <= new_mask;
            sweep_slot <= sweep_slot - SLOT_BITS'(1);
            state      <= ST_SW_ADDR;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_conn   <= pend_conn;
            out_mask   <= pend_mask;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - SLOT_BITS - MASK_BITS){1'b0}}, out_mask, out_conn};

endmodule
